### hw/rtl/fpa_pkg.sv
`default_nettype none

package fpa_pkg;

    // Number format and divider layout.
    localparam int unsigned FRAC_BITS     = 8;
    localparam int unsigned DIV_BITS_STEP = 4;
    localparam int unsigned DIV_STAGES    = 32 / DIV_BITS_STEP;
    localparam int unsigned QUEUE_DEPTH   = 2;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_INC      = 4'd10,
        OP_DEC      = 4'd11,
        OP_MIN      = 4'd12,
        OP_MAX      = 4'd13,
        OP_TO_INT   = 4'd14,
        OP_FROM_INT = 4'd15
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    // What the back end still has to do with a job.
    typedef enum logic [1:0] {
        K_SIMPLE = 2'd0,
        K_MUL    = 2'd1,
        K_DIV    = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        neg;
        logic        ovf;
        logic [31:0] x;     // multiplicand, or partial remainder
        logic [31:0] y;     // multiplier, or numerator bits still to shift in
        logic [31:0] den;
        logic [31:0] quo;
        logic [63:0] prod;
        logic [32:0] mag;
        logic [31:0] res;
        logic        cmp;
        t_status     st;
    } t_job;

    typedef struct packed {
        logic [31:0] res;
        logic        cmp;
        t_status     st;
    } t_result;

    // One back-end stage: optional multiply, optional product rounding,
    // and a few restoring division steps.
    function automatic t_job fpa_stage(input t_job j, input logic do_mul,
                                       input logic do_round);
        t_job        o;
        logic [32:0] part;
        logic [63:0] pmag;
        logic [63:0] m;
        logic        qbit;
        o = j;
        if (do_mul && j.kind == K_MUL) begin
            o.prod = 64'($signed(j.x) * $signed(j.y));
        end
        if (do_round && j.kind == K_MUL) begin
            pmag  = j.prod[63] ? (64'd0 - j.prod) : j.prod;
            m     = (pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            o.neg = j.prod[63];
            o.ovf = |m[63:33];
            o.mag = m[32:0];
        end
        if (j.kind == K_DIV) begin
            for (int i = 0; i < int'(DIV_BITS_STEP); i++) begin
                part = {o.x, o.y[31]};
                o.y  = {o.y[30:0], 1'b0};
                qbit = 1'b0;
                if (part >= {1'b0, o.den}) begin
                    part = part - {1'b0, o.den};
                    qbit = 1'b1;
                end
                o.x   = part[31:0];
                o.quo = {o.quo[30:0], qbit};
            end
        end
        return o;
    endfunction

    // Rounding of the quotient, sign and saturation.
    function automatic t_result fpa_finish(input t_job j);
        t_result     r;
        logic [32:0] mag;
        logic        sat;
        r.res = j.res;
        r.cmp = j.cmp;
        r.st  = j.st;
        if (j.kind != K_SIMPLE) begin
            if (j.kind == K_DIV) begin
                mag = {1'b0, j.quo} + (({j.x, 1'b0} >= {1'b0, j.den}) ? 33'd1 : 33'd0);
            end else begin
                mag = j.mag;
            end
            sat = j.ovf || (j.neg ? (mag > 33'h080000000) : (mag > 33'h07FFFFFFF));
            r.cmp = 1'b0;
            if (sat) begin
                r.res = j.neg ? 32'h80000000 : 32'h7FFFFFFF;
                r.st  = ST_OVF;
            end else begin
                r.res = j.neg ? (32'd0 - mag[31:0]) : mag[31:0];
                r.st  = ST_OK;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/fpa_in_if.sv
`default_nettype none

interface fpa_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  opcode;
    logic [31:0] operand_a;
    logic [31:0] operand_b;

    modport source (output valid, output opcode, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input opcode, input operand_a, input operand_b,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/fpa_out_if.sv
`default_nettype none

interface fpa_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_value;
    logic        compare_true;
    logic [1:0]  status;

    modport source (output valid, output result_value, output compare_true,
                    output status, input ready);
    modport sink   (input valid, input result_value, input compare_true,
                    input status, output ready);
endinterface

`default_nettype wire

### hw/rtl/fpa_front.sv
`default_nettype none

module fpa_front (
    fpa_in_if.sink        i_in,
    input  wire logic     i_full,
    output logic          o_push,
    output fpa_pkg::t_job o_job
);
    import fpa_pkg::*;

    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [32:0]        sum;
    logic [32:0]        dif;
    logic [32:0]        inc;
    logic [32:0]        dec;
    logic [31:0]        shl;
    logic [31:0]        amag;
    logic [31:0]        bmag;
    logic [31:0]        hi;
    t_job               job;

    assign a = $signed(i_in.operand_a);
    assign b = $signed(i_in.operand_b);

    // A transfer is taken whenever the queue has room.
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
    assign o_job      = job;

    // Wide sums for the saturating operations.
    assign sum  = {a[31], a} + {b[31], b};
    assign dif  = {a[31], a} - {b[31], b};
    assign inc  = {a[31], a} + 33'd1;
    assign dec  = {a[31], a} - 33'd1;
    assign shl  = i_in.operand_a << FRAC_BITS;
    assign amag = a[31] ? (32'd0 - i_in.operand_a) : i_in.operand_a;
    assign bmag = b[31] ? (32'd0 - i_in.operand_b) : i_in.operand_b;
    assign hi   = 32'({32'd0, amag} >> (32 - FRAC_BITS));

    // Decode: simple operations finish here, multiply and divide are set up.
    always_comb begin
        job      = '0;
        job.kind = K_SIMPLE;
        job.st   = ST_OK;
        unique case (t_opcode'(i_in.opcode))
            OP_ADD: begin
                job.res = (sum[32] != sum[31]) ? (sum[32] ? 32'h80000000 : 32'h7FFFFFFF)
                                               : sum[31:0];
                job.st  = (sum[32] != sum[31]) ? ST_OVF : ST_OK;
            end
            OP_SUB: begin
                job.res = (dif[32] != dif[31]) ? (dif[32] ? 32'h80000000 : 32'h7FFFFFFF)
                                               : dif[31:0];
                job.st  = (dif[32] != dif[31]) ? ST_OVF : ST_OK;
            end
            OP_MUL: begin
                job.kind = K_MUL;
                job.x    = i_in.operand_a;
                job.y    = i_in.operand_b;
            end
            OP_DIV: begin
                if (i_in.operand_b == 32'd0) begin
                    job.st = ST_DIV0;
                end else begin
                    job.kind = K_DIV;
                    job.neg  = a[31] != b[31];
                    job.x    = hi;
                    job.y    = amag << FRAC_BITS;
                    job.den  = bmag;
                    job.ovf  = hi >= bmag;
                end
            end
            OP_GT: job.cmp = a > b;
            OP_LT: job.cmp = a < b;
            OP_GE: job.cmp = a >= b;
            OP_LE: job.cmp = a <= b;
            OP_EQ: job.cmp = a == b;
            OP_NE: job.cmp = a != b;
            OP_INC: begin
                job.res = (inc[32] != inc[31]) ? 32'h7FFFFFFF : inc[31:0];
                job.st  = (inc[32] != inc[31]) ? ST_OVF : ST_OK;
            end
            OP_DEC: begin
                job.res = (dec[32] != dec[31]) ? 32'h80000000 : dec[31:0];
                job.st  = (dec[32] != dec[31]) ? ST_OVF : ST_OK;
            end
            OP_MIN: job.res = (a < b) ? i_in.operand_a : i_in.operand_b;
            OP_MAX: job.res = (a > b) ? i_in.operand_a : i_in.operand_b;
            OP_TO_INT: job.res = 32'(a >>> FRAC_BITS);
            OP_FROM_INT: begin
                if (($signed(shl) >>> FRAC_BITS) != a) begin
                    job.res = a[31] ? 32'h80000000 : 32'h7FFFFFFF;
                    job.st  = ST_OVF;
                end else begin
                    job.res = shl;
                end
            end
            default: job = '0;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/fpa_queue.sv
`default_nettype none

module fpa_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire fpa_pkg::t_job  i_job,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output fpa_pkg::t_job       o_job
);
    import fpa_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);

    t_job                r_mem [QUEUE_DEPTH];
    logic [PW-1:0]       r_wr;
    logic [PW-1:0]       r_rd;
    logic [PW:0]         r_count;
    logic [PW-1:0]       n_wr;
    logic [PW-1:0]       n_rd;
    logic [PW:0]         n_count;
    logic                do_push;
    logic                do_pop;

    // The queue reports itself full during reset so that no transfer is taken then.
    assign o_full  = !i_rst_n || (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = r_count == '0;
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and fill count update.
    always_comb begin
        n_wr    = do_push ? ((r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd    = do_pop  ? ((r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1) : r_rd;
        n_count = r_count + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PW+1)'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into a full queue");
    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> r_count == $past(r_count) - 1'b1)
        else $error("pop without push did not lower the count");

endmodule

`default_nettype wire

### hw/rtl/fpa_back.sv
`default_nettype none

module fpa_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire fpa_pkg::t_job i_job,
    output logic               o_pop,
    fpa_out_if.source          o_out
);
    import fpa_pkg::*;

    t_job                  r_job [DIV_STAGES];
    logic [DIV_STAGES-1:0] r_vld;
    t_job                  n_job [DIV_STAGES];
    t_result               r_res;
    logic                  r_out_vld;
    t_result               n_res;
    logic                  advance;

    // The whole pipe moves whenever the output register is free or drained.
    assign advance = !r_out_vld || o_out.ready;
    assign o_pop   = advance && !i_empty;

    // Stage logic: multiply in the first stage, round the product in the second,
    // and a few quotient bits in every stage.
    for (genvar k = 0; k < int'(DIV_STAGES); k++) begin : g_stage
        if (k == 0) begin : g_first
            always_comb begin
                n_job[k] = fpa_stage(i_job, 1'b1, 1'b0);
            end
        end else begin : g_next
            always_comb begin
                n_job[k] = fpa_stage(r_job[k-1], 1'b0, 1'(k == 1));
            end
        end

        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_job[k] <= n_job[k];
            end
        end
    end

    assign n_res = fpa_finish(r_job[DIV_STAGES-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_vld     <= {r_vld[DIV_STAGES-2:0], !i_empty};
            r_out_vld <= r_vld[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.result_value = r_res.res;
    assign o_out.compare_true = r_res.cmp;
    assign o_out.status       = r_res.st;

    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.cmp) |-> (r_res.res == 32'd0 && r_res.st == ST_OK))
        else $error("comparison result carries a value or status");
    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_res.st == ST_DIV0) |-> (r_res.res == 32'd0 && !r_res.cmp))
        else $error("divide by zero result not cleared");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_out.ready) |=> (r_out_vld && $stable(r_res) && $stable(r_vld)))
        else $error("pipeline moved while the output was stalled");

endmodule

`default_nettype wire

### hw/rtl/fixed_point_q24_8_alu_unit.sv
// Channel  | Direction | Handshake      | Payload
// i_in     | in        | valid / ready  | opcode, operand_a, operand_b
// o_out    | out       | valid / ready  | result_value, compare_true, status
//
// A new operation can be taken every cycle while the queue has room; each result
// passes through the queue, eight pipeline stages and the output register in turn.
// The divider resolves four quotient bits per stage.
// Reset is synchronous and active low; it empties the queue and the pipeline.
// A stalled output freezes the whole pipeline; the two-entry queue keeps the input
// taking transfers until it fills.
`default_nettype none

module fixed_point_q24_8_alu_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fpa_in_if.sink    i_in,
    fpa_out_if.source o_out
);
    import fpa_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job front_job;
    t_job head_job;

    fpa_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_job  (front_job)
    );

    fpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (head_job)
    );

    fpa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

### test/fixed_point_q24_8_alu_unit_test.sv
module fixed_point_q24_8_alu_unit_test;
    import fpa_pkg::*;

    // Expected outcome of one operation.
    typedef struct {
        logic [31:0] res;
        logic        cmp;
        logic [1:0]  st;
    } t_alu_outcome;

    // Predicts each result and keeps the outcomes still owed by the block.
    class alu_scoreboard;
        t_alu_outcome owed[$];
        int unsigned  mismatches;

        function longint clamp(input longint v, inout logic [1:0] st);
            if (v > 64'sd2147483647) begin
                st = ST_OVF;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                st = ST_OVF;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function void note_operation(input t_opcode op, input logic [31:0] ra,
                                     input logic [31:0] rb);
            t_alu_outcome o;
            longint       a, b, p, m, n, d;
            a = longint'($signed(ra));
            b = longint'($signed(rb));
            o.res = '0;
            o.cmp = 1'b0;
            o.st  = ST_OK;
            case (op)
                OP_ADD: o.res = clamp(a + b, o.st);
                OP_SUB: o.res = clamp(a - b, o.st);
                OP_MUL: begin
                    p = a * b;
                    m = ((p < 0 ? -p : p) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
                    o.res = clamp(p < 0 ? -m : m, o.st);
                end
                OP_DIV: begin
                    if (b == 0) begin
                        o.st = ST_DIV0;
                    end else begin
                        // Magnitudes stay below 2^40, so the doubled values fit.
                        n = (a < 0 ? -a : a) <<< FRAC_BITS;
                        d = b < 0 ? -b : b;
                        m = (2 * n + d) / (2 * d);
                        o.res = clamp(((a < 0) != (b < 0)) ? -m : m, o.st);
                    end
                end
                OP_GT: o.cmp = a > b;
                OP_LT: o.cmp = a < b;
                OP_GE: o.cmp = a >= b;
                OP_LE: o.cmp = a <= b;
                OP_EQ: o.cmp = a == b;
                OP_NE: o.cmp = a != b;
                OP_INC: o.res = clamp(a + 1, o.st);
                OP_DEC: o.res = clamp(a - 1, o.st);
                OP_MIN: o.res = (a < b) ? a : b;
                OP_MAX: o.res = (a > b) ? a : b;
                OP_TO_INT: o.res = a >>> FRAC_BITS;
                default: o.res = clamp(a * (64'sd1 <<< FRAC_BITS), o.st);
            endcase
            owed.push_back(o);
        endfunction

        function void check_result(input logic [31:0] res, input logic cmp,
                                   input logic [1:0] st);
            t_alu_outcome e;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result res=%h cmp=%b st=%0d", res, cmp, st);
                return;
            end
            e = owed.pop_front();
            if (res !== e.res || cmp !== e.cmp || st !== e.st) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected res=%h cmp=%b st=%0d, got res=%h cmp=%b st=%0d",
                             e.res, e.cmp, e.st, res, cmp, st);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   send_idle = 0;
    int   recv_stall = 0;
    alu_scoreboard board = new();

    fpa_in_if  in_ch();
    fpa_out_if out_ch();

    fixed_point_q24_8_alu_unit uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.opcode    = '0;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        out_ch.ready    = 1'b0;
    end

    // Receiver: random stalls, every transfer checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready)
                board.check_result(out_ch.result_value, out_ch.compare_true, out_ch.status);
            out_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Drives one operation and holds it until its transfer.
    task automatic send_operation(input t_opcode op, input logic [31:0] a,
                                  input logic [31:0] b);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= op;
        in_ch.operand_a <= a;
        in_ch.operand_b <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.note_operation(op, a, b);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(4000)) - 2000);
            2: return {{16{1'($urandom_range(1))}}, 16'($urandom())};
            3: return $urandom_range(1) ? 32'h7FFFFFFF - $urandom_range(300)
                                        : 32'h80000000 + $urandom_range(300);
            4: return $urandom() >> $urandom_range(31);
            default: return {{8{1'($urandom_range(1))}}, 24'($urandom())};
        endcase
    endfunction

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.owed.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] a, b;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every operation, overflow and zero divisor.
        send_operation(OP_ADD, 32'h7FFFFFFF, 32'h1);
        send_operation(OP_SUB, 32'h80000000, 32'h1);
        send_operation(OP_MUL, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_operation(OP_MUL, 32'h80000000, 32'h80000000);
        send_operation(OP_MUL, 32'hFFFFFF80, 32'h00000001);
        send_operation(OP_DIV, 32'h12345678, 32'h0);
        send_operation(OP_DIV, 32'h80000000, 32'h00000001);
        send_operation(OP_DIV, 32'h80000000, 32'hFFFFFFFF);
        send_operation(OP_DIV, 32'h00000001, 32'h00000200);
        send_operation(OP_GT, 32'h80000000, 32'h7FFFFFFF);
        send_operation(OP_LT, 32'h80000000, 32'h7FFFFFFF);
        send_operation(OP_GE, 32'h5, 32'h5);
        send_operation(OP_LE, 32'h5, 32'h4);
        send_operation(OP_EQ, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_operation(OP_NE, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_operation(OP_INC, 32'h7FFFFFFF, 32'h0);
        send_operation(OP_DEC, 32'h80000000, 32'hFFFFFFFF);
        send_operation(OP_MIN, 32'h7, 32'h7);
        send_operation(OP_MAX, 32'h80000000, 32'h7FFFFFFF);
        send_operation(OP_TO_INT, 32'hFFFFFFFF, 32'h0);
        send_operation(OP_TO_INT, 32'h80000000, 32'h0);
        send_operation(OP_FROM_INT, 32'h00800000, 32'h0);
        send_operation(OP_FROM_INT, 32'hFF7FFFFF, 32'h0);
        drain_results();

        // Random operations over four idling phases.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 83; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 83; end
                default: begin send_idle = 37; recv_stall = 37; end
            endcase
            for (int k = 0; k < 232; k++) begin
                a = pick_operand();
                b = ($urandom_range(15) == 0) ? 32'h0 : pick_operand();
                send_operation(t_opcode'($urandom_range(15)), a, b);
            end
            drain_results();
        end

        repeat (20) @(posedge i_clk);
        if (board.mismatches == 0 && board.owed.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule

### fixed_point_q24_8_alu_unit.f
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_in_if.sv
hw/rtl/fpa_out_if.sv
hw/rtl/fpa_front.sv
hw/rtl/fpa_queue.sv
hw/rtl/fpa_back.sv
hw/rtl/fixed_point_q24_8_alu_unit.sv
test/fixed_point_q24_8_alu_unit_test.sv
